### hdl/spkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spkd_pkg
// Shared types for the serial packet deframer: controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package spkd_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'h2B;
  localparam logic [7:0] ID_MAX_SMALL = 8'd3;
  localparam logic [7:0] ID_WIDE      = 8'hFF;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_ID,
    ST_LEN,
    ST_FILL,
    ST_TRAIL,
    ST_EMIT
  } spkd_state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;       // drop held id, length and fill count
    logic take_id;
    logic take_len;
    logic store_byte;
    logic start_emit;
    logic emit_load;   // read one stored byte into the output register
  } spkd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_sync;
    logic byte_zero;
    logic id_bad;
    logic len_big;
    logic fill_last;
    logic emit_last;
    logic out_free;
  } spkd_status_t;

endpackage

### hdl/spkd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spkd_ctrl
// Controller state machine: sync hunt, id, length, data fill, trailing byte
// and the output run.
// ----------------------------------------------------------------------------
module spkd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spkd_pkg::spkd_status_t status,
  output spkd_pkg::spkd_cmd_t    cmd
);
  import spkd_pkg::*;

  spkd_state_t state_r, state_nxt;
  logic        accept;

  assign accept = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b1;
    case (state_r)
      ST_HUNT: begin
        if (accept && status.is_sync) state_nxt = ST_ID;
      end
      ST_ID: begin
        if (accept) begin
          if (status.id_bad) begin
            cmd.clear = 1'b1;
            state_nxt = ST_HUNT;
          end else if (!status.byte_zero) begin
            cmd.take_id = 1'b1;
            state_nxt   = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (accept) begin
          if (status.len_big) begin
            cmd.clear = 1'b1;
            state_nxt = ST_HUNT;
          end else if (!status.byte_zero) begin
            cmd.take_len = 1'b1;
            state_nxt    = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (accept) begin
          cmd.store_byte = 1'b1;
          if (status.fill_last) state_nxt = ST_TRAIL;
        end
      end
      ST_TRAIL: begin
        // trailing byte value is not checked
        if (accept) begin
          cmd.start_emit = 1'b1;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        in_ready = 1'b0;
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_HUNT;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

endmodule

### hdl/spkd_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spkd_dpath
// Datapath: held id and length, fill and emit counters, payload memory and
// the output register.
// ----------------------------------------------------------------------------
module spkd_dpath #(
  parameter int MAX_PAYLOAD = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_rx_byte,
  input  spkd_pkg::spkd_cmd_t    cmd,
  output spkd_pkg::spkd_status_t status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_packet_id,
  output logic [4:0]             out_packet_length,
  output logic [3:0]             out_byte_index,
  output logic [7:0]             out_data_byte,
  output logic                   out_last_byte
);
  import spkd_pkg::*;

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]       held_id_r;
  logic [LEN_W-1:0] held_length_r;
  logic [LEN_W-1:0] fill_index_r;
  logic [LEN_W-1:0] emit_cnt_r;
  logic [7:0]       mem [MAX_PAYLOAD];

  logic             out_valid_r;
  logic [7:0]       out_id_r;
  logic [4:0]       out_len_r;
  logic [3:0]       out_idx_r;
  logic [7:0]       out_data_r;
  logic             out_last_r;

  logic [LEN_W+4:0] len_ext;
  logic [LEN_W+3:0] idx_ext;

  // byte classification
  assign status.is_sync   = (in_rx_byte == SYNC_BYTE);
  assign status.byte_zero = (in_rx_byte == 8'd0);
  assign status.id_bad    = (in_rx_byte > ID_MAX_SMALL) && (in_rx_byte != ID_WIDE);
  assign status.len_big   = (in_rx_byte > 8'(MAX_PAYLOAD));
  assign status.fill_last = ((fill_index_r + LEN_W'(1)) == held_length_r);
  assign status.emit_last = ((emit_cnt_r + LEN_W'(1)) == held_length_r);
  assign status.out_free  = !out_valid_r || out_ready;

  // field fitting to output widths
  assign len_ext = {5'd0, held_length_r};
  assign idx_ext = {4'd0, emit_cnt_r};

  // packet header and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_id_r     <= '0;
      held_length_r <= '0;
      fill_index_r  <= '0;
      emit_cnt_r    <= '0;
    end else begin
      if (cmd.take_id)    held_id_r     <= in_rx_byte;
      if (cmd.take_len)   held_length_r <= in_rx_byte[LEN_W-1:0];
      if (cmd.store_byte) fill_index_r  <= fill_index_r + LEN_W'(1);
      if (cmd.start_emit) emit_cnt_r    <= '0;
      else if (cmd.emit_load) emit_cnt_r <= emit_cnt_r + LEN_W'(1);
      if (cmd.clear) begin
        held_id_r     <= '0;
        held_length_r <= '0;
        fill_index_r  <= '0;
      end
    end
  end

  // payload memory write
  always_ff @(posedge clk) begin
    if (cmd.store_byte) mem[fill_index_r[IDX_W-1:0]] <= in_rx_byte;
  end

  // output register, memory read data lands here
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_data_r <= mem[emit_cnt_r[IDX_W-1:0]];
      out_id_r   <= held_id_r;
      out_len_r  <= len_ext[4:0];
      out_idx_r  <= idx_ext[3:0];
      out_last_r <= status.emit_last;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_id     = out_id_r;
  assign out_packet_length = out_len_r;
  assign out_byte_index    = out_idx_r;
  assign out_data_byte     = out_data_r;
  assign out_last_byte     = out_last_r;

  // checks
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take_id, cmd.take_len, cmd.store_byte, cmd.start_emit, cmd.emit_load}))
    else $error("spkd_dpath: overlapping commands");

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_byte |-> (fill_index_r < held_length_r))
    else $error("spkd_dpath: store beyond packet length");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> (emit_cnt_r < held_length_r))
    else $error("spkd_dpath: emit beyond packet length");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && status.emit_last) |=> (held_length_r == '0) && out_valid_r && out_last_r)
    else $error("spkd_dpath: packet state not cleared after last item");

endmodule

### hdl/serial_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_packet_deframer
// Hunts for sync, takes id, length and data bytes of a serial packet and
// sends the stored data out as a run of items after the trailing byte.
// ----------------------------------------------------------------------------
// Input bytes are taken one per cycle while hunting, filling or waiting.
// After the trailing byte the run of L items leaves one per cycle while the
// receiver takes them, through the registered memory read; input is held
// off until the last item is loaded. Synchronous active-low reset returns
// to the sync hunt with no packet held; the payload memory is not cleared.
module serial_packet_deframer #(
  parameter int MAX_PAYLOAD = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_packet_id,
  output logic [4:0] out_packet_length,
  output logic [3:0] out_byte_index,
  output logic [7:0] out_data_byte,
  output logic       out_last_byte
);
  import spkd_pkg::*;

  spkd_cmd_t    cmd;
  spkd_status_t status;

  spkd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  spkd_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_packet_id     (out_packet_id),
    .out_packet_length (out_packet_length),
    .out_byte_index    (out_byte_index),
    .out_data_byte     (out_data_byte),
    .out_last_byte     (out_last_byte)
  );

endmodule

### tb/serial_packet_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_packet_deframer_test
// Feeds byte streams into the deframer and checks every emitted data item
// against a cycle-free packet predictor. A short directed table covers sync
// hunting, zero id and zero length waits, bad ids, oversized lengths and
// short lengths. Random packets follow, mostly well formed, run through
// phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module serial_packet_deframer_test;
  import spkd_pkg::*;

  localparam int MAX_PAYLOAD  = 16;
  localparam int RANDOM_ITEMS = 345;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] id;
    logic [4:0] len;
    logic [3:0] idx;
    logic [7:0] data;
    logic       last;
  } deframed_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    deframed_t  result;
  } dir_row_t;

  localparam deframed_t NO_RESULT = '0;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_packet_id;
  logic [4:0] out_packet_length;
  logic [3:0] out_byte_index;
  logic [7:0] out_data_byte;
  logic       out_last_byte;

  // predictor state
  logic       sync_seen = 1'b0;
  logic [7:0] held_id = 8'h00;
  logic [4:0] held_len = 5'd0;
  logic [4:0] fill_count = 5'd0;
  logic [7:0] payload [MAX_PAYLOAD];

  deframed_t  run_q [$];
  deframed_t  expected_payload_q [$];
  int         mismatch_count = 0;
  int         useful_items = 0;
  int         cycle_count = 0;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;

  // directed stream: hunt noise, waits, drops and small packets
  dir_row_t directed_rows [25] = '{
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{SYNC_BYTE, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'hA5, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{8'h01, 5'd1, 4'd0, 8'hA5, 1'b1}},
    '{SYNC_BYTE, 1'b0, NO_RESULT},
    '{8'h04, 1'b0, NO_RESULT},
    '{SYNC_BYTE, 1'b0, NO_RESULT},
    '{ID_WIDE, 1'b0, NO_RESULT},
    '{8'h11, 1'b0, NO_RESULT},
    '{SYNC_BYTE, 1'b0, NO_RESULT},
    '{8'h03, 1'b0, NO_RESULT},
    '{8'h02, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h5A, 1'b0, NO_RESULT},
    '{SYNC_BYTE, 1'b0, NO_RESULT},
    '{ID_WIDE, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, '{8'hFF, 5'd1, 4'd0, 8'h00, 1'b1}}
  };

  serial_packet_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_packet_id    (out_packet_id),
    .out_packet_length(out_packet_length),
    .out_byte_index   (out_byte_index),
    .out_data_byte    (out_data_byte),
    .out_last_byte    (out_last_byte)
  );

  always #10 clk = ~clk;

  // runs one accepted byte through the packet state, fills run_q with the
  // items it releases; returns 1 when the byte was dropped while hunting
  function automatic bit deframe_byte(input logic [7:0] b);
    deframed_t r;
    run_q.delete();
    if (!sync_seen) begin
      if (b == SYNC_BYTE) begin
        sync_seen = 1'b1;
        return 1'b0;
      end
      return 1'b1;
    end
    // id stage, zero keeps waiting
    if (held_id == 8'h00) begin
      if (b > ID_MAX_SMALL && b != ID_WIDE) sync_seen = 1'b0;
      else held_id = b;
      return 1'b0;
    end
    // length stage, zero keeps waiting
    if (held_len == 5'd0) begin
      if (b > MAX_PAYLOAD) begin
        sync_seen = 1'b0;
        held_id = 8'h00;
      end else begin
        held_len = b[4:0];
      end
      return 1'b0;
    end
    if (fill_count < held_len) begin
      payload[fill_count[3:0]] = b;
      fill_count++;
      return 1'b0;
    end
    // trailing byte releases the stored run
    for (int k = 0; k < held_len; k++) begin
      r.id   = held_id;
      r.len  = held_len;
      r.idx  = k[3:0];
      r.data = payload[k];
      r.last = (k + 1 == held_len);
      run_q.push_back(r);
    end
    sync_seen  = 1'b0;
    held_id    = 8'h00;
    held_len   = 5'd0;
    fill_count = 5'd0;
    return 1'b0;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // drive one byte from a falling edge, hold until taken, leave at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit typed, input deframed_t want);
    bit ignored;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    ignored = deframe_byte(b);
    if (typed) expected_payload_q.push_back(want);
    else foreach (run_q[i]) expected_payload_q.push_back(run_q[i]);
    if (!ignored) useful_items++;
    @(negedge clk);
  endtask

  task automatic send_raw(input logic [7:0] b);
    send_byte(b, 1'b0, NO_RESULT);
  endtask

  function automatic logic [7:0] good_id();
    int unsigned pick;
    pick = $urandom_range(3);
    return (pick == 3) ? ID_WIDE : 8'(pick + 1);
  endfunction

  // one random sequence: mostly well formed packets, some noise and drops
  task automatic send_packet();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(99);
    if ($urandom_range(3) == 0) send_raw(8'($urandom));
    if (kind < 8) begin
      send_raw(8'($urandom));
    end else if (kind < 16) begin
      send_raw(SYNC_BYTE);
      send_raw(8'($urandom_range(254, 4)));
    end else if (kind < 24) begin
      send_raw(SYNC_BYTE);
      send_raw(good_id());
      send_raw(8'($urandom_range(255, MAX_PAYLOAD + 1)));
    end else begin
      send_raw(SYNC_BYTE);
      if ($urandom_range(4) == 0) send_raw(8'h00);
      send_raw(good_id());
      if ($urandom_range(4) == 0) send_raw(8'h00);
      kind = $urandom_range(99);
      if (kind < 10) len = MAX_PAYLOAD;
      else if (kind < 25) len = 1;
      else len = $urandom_range(6, 1);
      send_raw(8'(len));
      repeat (len) send_raw(8'($urandom));
      send_raw(8'($urandom));
    end
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // result checker
  always @(posedge clk) begin : result_check
    deframed_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_payload_q.size() == 0) begin
        $display("%0t unexpected item: id %0h len %0d idx %0d data %0h last %0b", $time,
                 out_packet_id, out_packet_length, out_byte_index, out_data_byte,
                 out_last_byte);
        mismatch_count++;
      end else begin
        want = expected_payload_q.pop_front();
        compare_field("packet_id", want.id, out_packet_id);
        compare_field("packet_length", want.len, out_packet_length);
        compare_field("byte_index", want.idx, out_byte_index);
        compare_field("data_byte", want.data, out_data_byte);
        compare_field("last_byte", want.last, out_last_byte);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].result);

    // random packets across idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
      endcase
      while (useful_items < 25 + (phase + 1) * RANDOM_ITEMS / 4) send_packet();
    end
    in_valid <= 1'b0;

    // drain
    while (expected_payload_q.size() != 0) @(posedge clk);
    repeat (MAX_PAYLOAD + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### serial_packet_deframer.f
hdl/spkd_pkg.sv
hdl/spkd_ctrl.sv
hdl/spkd_dpath.sv
hdl/serial_packet_deframer.sv
tb/serial_packet_deframer_test.sv
